// ----- rtl/lpwe_pkg.sv -----
// Shared types, codes and table-building functions for the local path window extractor.
`default_nettype none

package lpwe_pkg;

   // Operation codes carried by an input word.
   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] REG_SEARCH_WINDOW = 2'd0;
   localparam logic [1:0] REG_POSES_AHEAD   = 2'd1;
   localparam logic [1:0] REG_OUTPUT_FRAME  = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [7:0] SEARCH_WINDOW_RST = 8'd50;
   localparam logic [5:0] POSES_AHEAD_RST   = 6'd20;

   // pi/2 in Q2.30, used while building the sine table.
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic append;   // store the input waypoint
      logic clear;    // empty the path
      logic start;    // latch pose, set up search
      logic issue;    // read path entry at the walk address
      logic finish;   // commit tracked index, load ego word
      logic advance;  // step to the next emitted word
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic search_end;
      logic pipe_busy;
      logic emit_hit;
      logic k_last;
      logic result_ready;
   } dp_status_type;

   // Quarter-wave sine sample r of a table with 2^bits entries, Q1.16.
   function automatic logic [16:0] quarter_sine(int unsigned r, int unsigned bits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned mag;
      longint unsigned v;
      longint          sum;
      x   = (longint'(r) * HALF_PI_Q30) >> (bits - 2);
      x2  = (x * x) >> 30;
      mag = x;
      sum = longint'(x);
      for (int k = 1; k <= 6; k++) begin
         mag = (mag * x2) >> 30;
         // Divide by (2k)(2k+1) for the term of order 2k+1.
         case (k)
            1:       mag = mag / 64'd6;
            2:       mag = mag / 64'd20;
            3:       mag = mag / 64'd42;
            4:       mag = mag / 64'd72;
            5:       mag = mag / 64'd110;
            default: mag = mag / 64'd156;
         endcase
         if ((k % 2) == 1) begin
            sum = sum - longint'(mag);
         end else begin
            sum = sum + longint'(mag);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      v = (longint'(sum) + 64'd8192) >> 14;
      if (v > 64'd65536) begin
         v = 64'd65536;
      end
      return v[16:0];
   endfunction

   // Full-circle sine table entry n, signed Q1.16 in 18 bits.
   function automatic logic signed [17:0] sine_entry(int unsigned n, int unsigned bits);
      int unsigned      q;
      int unsigned      r;
      int unsigned      quarter;
      logic signed [17:0] s;
      quarter = 1 << (bits - 2);
      q       = (n >> (bits - 2)) & 3;
      r       = n & (quarter - 1);
      if ((q & 1) != 0) begin
         s = $signed({1'b0, quarter_sine(quarter - r, bits)});
      end else begin
         s = $signed({1'b0, quarter_sine(r, bits)});
      end
      if ((q & 2) != 0) begin
         s = -s;
      end
      return s;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/local_path_window_extractor.sv -----
// Top level of the local path window extractor.
//
// Input words (req_*) carry an operation and a pose or waypoint. An append
// stores a waypoint in the path memory unless the memory is full; a clear
// empties the path and resets the tracked index. A pose query reads the path
// memory one entry a cycle over the n entries of the search window that hold
// waypoints; once the four-stage search pipe has drained, the ego word is
// shown.
// The result channel (rsp_*) then shows the ego word, followed by
// poses_ahead words. A word read from the path passes through the transform
// pipe before it is shown; a padding word is shown in the next cycle. The
// single read port of the path memory and the four-stage transform pipe set
// how long a query holds off the next input word.
// req_stall is high from the acceptance of a query until its last word is
// taken. When the receiver stalls, the shown word holds and the block waits.
// Reset empties the path, zeroes the tracked index and loads the register
// defaults (window 50, 20 poses, vehicle frame); the path memory itself is
// not cleared and needs no clearing pass.
`default_nettype none

module local_path_window_extractor #(
   parameter int PATH_DEPTH      = 4096,
   parameter int TRIG_TABLE_BITS = 10
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_operation,
   input  wire logic signed [31:0] req_coord_x,
   input  wire logic signed [31:0] req_coord_y,
   input  wire logic signed [15:0] req_heading,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_out_x,
   output logic signed [31:0]      rsp_out_y,
   output logic signed [15:0]      rsp_out_heading,
   output logic                    rsp_is_ego,
   output logic [11:0]             rsp_start_index,
   output logic                    rsp_last,
   input  wire logic               csr_wr_en,
   input  wire logic [1:0]         csr_index,
   input  wire logic [7:0]         csr_wr_data
);

   lpwe_pkg::dp_cmd_type    cmd;
   lpwe_pkg::dp_status_type st;

   // Sequencing of the query.
   lpwe_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .cmd           (cmd),
      .st            (st)
   );

   // Storage and arithmetic.
   lpwe_dpath #(
      .PATH_DEPTH      (PATH_DEPTH),
      .TRIG_TABLE_BITS (TRIG_TABLE_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_heading     (req_heading),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_heading (rsp_out_heading),
      .rsp_is_ego      (rsp_is_ego),
      .rsp_start_index (rsp_start_index),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

// ----- rtl/lpwe_ctrl.sv -----
// Controller state machine for the local path window extractor.
`default_nettype none

module lpwe_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_operation,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output lpwe_pkg::dp_cmd_type       cmd,
   input  wire lpwe_pkg::dp_status_type st
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SEARCH = 5'b00010,
      ST_DRAIN  = 5'b00100,
      ST_SHOW   = 5'b01000,
      ST_WAIT   = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_acc;
   logic      rsp_acc;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_SHOW);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_acc   = rsp_valid && !rsp_stall;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_operation)
                  lpwe_pkg::OP_APPEND: cmd.append = 1'b1;
                  lpwe_pkg::OP_CLEAR:  cmd.clear  = 1'b1;
                  lpwe_pkg::OP_QUERY: begin
                     cmd.start = 1'b1;
                     state_in  = ST_SEARCH;
                  end
                  default: ;
               endcase
            end
         end
         ST_SEARCH: begin
            if (st.search_end) begin
               state_in = ST_DRAIN;
            end else begin
               cmd.issue = 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!st.pipe_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_SHOW;
            end
         end
         ST_SHOW: begin
            if (rsp_acc) begin
               if (st.k_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  if (st.emit_hit) begin
                     cmd.issue = 1'b1;
                     state_in  = ST_WAIT;
                  end
               end
            end
         end
         ST_WAIT: begin
            if (st.result_ready) begin
               state_in = ST_SHOW;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/lpwe_dpath.sv -----
// Datapath: path memory, trig table, search and frame transform pipeline, output word.
`default_nettype none

module lpwe_dpath #(
   parameter int PATH_DEPTH      = 4096,
   parameter int TRIG_TABLE_BITS = 10
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lpwe_pkg::dp_cmd_type  cmd,
   output lpwe_pkg::dp_status_type    st,
   input  wire logic signed [31:0]    req_coord_x,
   input  wire logic signed [31:0]    req_coord_y,
   input  wire logic signed [15:0]    req_heading,
   input  wire logic                  csr_wr_en,
   input  wire logic [1:0]            csr_index,
   input  wire logic [7:0]            csr_wr_data,
   output logic signed [31:0]         rsp_out_x,
   output logic signed [31:0]         rsp_out_y,
   output logic signed [15:0]         rsp_out_heading,
   output logic                       rsp_is_ego,
   output logic [11:0]                rsp_start_index,
   output logic                       rsp_last
);

   localparam int IDX_W = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
   localparam int CNT_W = IDX_W + 1;
   localparam int END_W = ((CNT_W > 8) ? CNT_W : 8) + 1;
   localparam int TAB_N = 1 << TRIG_TABLE_BITS;
   localparam int TAB_Q = TAB_N / 4;

   // Path memory.
   logic signed [31:0] mem_x [PATH_DEPTH];
   logic signed [31:0] mem_y [PATH_DEPTH];
   logic [15:0]        mem_h [PATH_DEPTH];

   // Sine table, built from constants.
   logic signed [17:0] sin_tab [TAB_N];
   for (genvar g = 0; g < TAB_N; g++) begin : g_tab
      assign sin_tab[g] = lpwe_pkg::sine_entry(g, TRIG_TABLE_BITS);
   end

   // Configuration and path state.
   logic [7:0]         window_ff;
   logic [5:0]         poses_ff;
   logic               frame_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [IDX_W-1:0]   tracked_ff;
   logic [IDX_W-1:0]   tracked_in;

   // Query state.
   logic signed [31:0] vx_ff;
   logic signed [31:0] vy_ff;
   logic [15:0]        vh_ff;
   logic signed [17:0] cos_ff;
   logic signed [17:0] sin_ff;
   logic [CNT_W-1:0]   addr_ff;
   logic [CNT_W-1:0]   end_ff;
   logic [5:0]         k_ff;
   logic               search_mode_ff;
   logic               found_ff;
   logic [64:0]        best_dist_ff;
   logic [IDX_W-1:0]   best_idx_ff;

   // Pipeline stages.
   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [31:0] x1_ff, y1_ff, x2_ff, y2_ff, x3_ff, y3_ff, x4_ff, y4_ff;
   logic [15:0]        h1_ff, h2_ff, h3_ff, h4_ff;
   logic [IDX_W-1:0]   i1_ff, i2_ff, i3_ff, i4_ff;
   logic signed [32:0] dx_ff, dy_ff;
   logic signed [50:0] p_xc_ff, p_ys_ff, p_xs_ff, p_yc_ff;
   logic [63:0]        sqx_ff, sqy_ff;
   logic signed [51:0] dot_ff, ry_ff;
   logic [64:0]        dist_ff;

   // Output word.
   logic signed [31:0] out_x_ff, out_y_ff;
   logic [15:0]        out_h_ff;
   logic               is_ego_ff;

   // Combinational helpers.
   logic [TRIG_TABLE_BITS-1:0] sin_idx;
   logic [TRIG_TABLE_BITS-1:0] cos_idx;
   logic [END_W-1:0]           end_sum;
   logic [END_W-1:0]           count_ext;
   logic signed [32:0]         dx_in, dy_in;
   logic [32:0]                ax, ay;
   logic [65:0]                sqx_full, sqy_full;
   logic signed [50:0]         p_xc_in, p_ys_in, p_xs_in, p_yc_in;
   logic                       better;

   // Shift right by 16 rounding half away from zero, saturated to 32 bits.
   function automatic logic [31:0] round_sat(logic signed [51:0] v);
      logic [51:0] mag;
      logic [52:0] sum;
      logic [36:0] r;
      logic [31:0] res;
      mag = v[51] ? 52'(-v) : 52'(v);
      sum = {1'b0, mag} + 53'd32768;
      r   = sum[52:16];
      if (v[51]) begin
         res = (r > 37'h0080000000) ? 32'h80000000 : 32'(-r);
      end else begin
         res = (r > 37'h007FFFFFFF) ? 32'h7FFFFFFF : r[31:0];
      end
      return res;
   endfunction

   assign sin_idx   = req_heading[15 -: TRIG_TABLE_BITS];
   assign cos_idx   = sin_idx + TRIG_TABLE_BITS'(TAB_Q);
   assign end_sum   = END_W'(tracked_ff) + END_W'(window_ff);
   assign count_ext = END_W'(count_ff);
   assign tracked_in = found_ff ? best_idx_ff : tracked_ff;

   assign dx_in    = 33'(x1_ff) - 33'(vx_ff);
   assign dy_in    = 33'(y1_ff) - 33'(vy_ff);
   assign ax       = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
   assign ay       = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
   assign sqx_full = ax * ax;
   assign sqy_full = ay * ay;
   assign p_xc_in  = dx_ff * cos_ff;
   assign p_ys_in  = dy_ff * sin_ff;
   assign p_xs_in  = dx_ff * sin_ff;
   assign p_yc_in  = dy_ff * cos_ff;
   assign better   = (dot_ff > 52'sd0) && (!found_ff || (dist_ff < best_dist_ff));

   // Status to the controller.
   always_comb begin
      st.search_end   = (addr_ff >= end_ff);
      st.pipe_busy    = v1_ff || v2_ff || v3_ff || v4_ff;
      st.emit_hit     = (addr_ff < count_ff);
      st.k_last       = (k_ff == poses_ff);
      st.result_ready = v4_ff && !search_mode_ff;
   end

   // Path memory write and read.
   always_ff @(posedge clock) begin
      if (cmd.append && (count_ff < CNT_W'(PATH_DEPTH))) begin
         mem_x[count_ff[IDX_W-1:0]] <= req_coord_x;
         mem_y[count_ff[IDX_W-1:0]] <= req_coord_y;
         mem_h[count_ff[IDX_W-1:0]] <= req_heading;
      end
      if (cmd.issue) begin
         x1_ff <= mem_x[addr_ff[IDX_W-1:0]];
         y1_ff <= mem_y[addr_ff[IDX_W-1:0]];
         h1_ff <= mem_h[addr_ff[IDX_W-1:0]];
      end
   end

   // Control state: configuration, path count, tracked index, stage valids.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff      <= lpwe_pkg::SEARCH_WINDOW_RST;
         poses_ff       <= lpwe_pkg::POSES_AHEAD_RST;
         frame_ff       <= 1'b0;
         count_ff       <= '0;
         tracked_ff     <= '0;
         search_mode_ff <= 1'b0;
         found_ff       <= 1'b0;
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         v3_ff          <= 1'b0;
         v4_ff          <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               lpwe_pkg::REG_SEARCH_WINDOW: window_ff <= csr_wr_data;
               lpwe_pkg::REG_POSES_AHEAD:   poses_ff  <= csr_wr_data[5:0];
               lpwe_pkg::REG_OUTPUT_FRAME:  frame_ff  <= csr_wr_data[0];
               default: ;
            endcase
         end
         if (cmd.append && (count_ff < CNT_W'(PATH_DEPTH))) begin
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.clear) begin
            count_ff   <= '0;
            tracked_ff <= '0;
         end
         if (cmd.start) begin
            search_mode_ff <= 1'b1;
            found_ff       <= 1'b0;
         end
         if (cmd.finish) begin
            tracked_ff     <= tracked_in;
            search_mode_ff <= 1'b0;
         end
         if (v4_ff && search_mode_ff && better) begin
            found_ff <= 1'b1;
         end
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Query registers and walk counters.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         vx_ff   <= req_coord_x;
         vy_ff   <= req_coord_y;
         vh_ff   <= req_heading;
         sin_ff  <= sin_tab[sin_idx];
         cos_ff  <= sin_tab[cos_idx];
         addr_ff <= CNT_W'(tracked_ff);
         end_ff  <= (end_sum > count_ext) ? count_ff : CNT_W'(end_sum);
      end else if (cmd.finish) begin
         addr_ff <= CNT_W'(tracked_in);
         k_ff    <= '0;
      end else begin
         if (cmd.issue) begin
            addr_ff <= addr_ff + 1'b1;
         end
         if (cmd.advance) begin
            k_ff <= k_ff + 1'b1;
         end
      end
   end

   // Pipeline payload: difference, products, sums.
   always_ff @(posedge clock) begin
      i1_ff   <= addr_ff[IDX_W-1:0];
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      x2_ff   <= x1_ff;
      y2_ff   <= y1_ff;
      h2_ff   <= h1_ff;
      i2_ff   <= i1_ff;
      p_xc_ff <= p_xc_in;
      p_ys_ff <= p_ys_in;
      p_xs_ff <= p_xs_in;
      p_yc_ff <= p_yc_in;
      sqx_ff  <= sqx_full[63:0];
      sqy_ff  <= sqy_full[63:0];
      x3_ff   <= x2_ff;
      y3_ff   <= y2_ff;
      h3_ff   <= h2_ff;
      i3_ff   <= i2_ff;
      dot_ff  <= 52'(p_xc_ff) + 52'(p_ys_ff);
      ry_ff   <= 52'(p_yc_ff) - 52'(p_xs_ff);
      dist_ff <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
      x4_ff   <= x3_ff;
      y4_ff   <= y3_ff;
      h4_ff   <= h3_ff;
      i4_ff   <= i3_ff;
   end

   // Nearest-ahead tracking during the search.
   always_ff @(posedge clock) begin
      if (v4_ff && search_mode_ff && better) begin
         best_dist_ff <= dist_ff;
         best_idx_ff  <= i4_ff;
      end
   end

   // Output word: ego point, waypoint (transformed in the vehicle frame), or held copy as padding.
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         is_ego_ff <= 1'b1;
         if (frame_ff) begin
            out_x_ff <= vx_ff;
            out_y_ff <= vy_ff;
            out_h_ff <= vh_ff;
         end else begin
            out_x_ff <= '0;
            out_y_ff <= '0;
            out_h_ff <= '0;
         end
      end else begin
         if (cmd.advance) begin
            is_ego_ff <= 1'b0;
         end
         if (v4_ff && !search_mode_ff) begin
            if (frame_ff) begin
               out_x_ff <= x4_ff;
               out_y_ff <= y4_ff;
               out_h_ff <= h4_ff;
            end else begin
               out_x_ff <= round_sat(dot_ff);
               out_y_ff <= round_sat(ry_ff);
               out_h_ff <= h4_ff - vh_ff;
            end
         end
      end
   end

   assign rsp_out_x       = out_x_ff;
   assign rsp_out_y       = out_y_ff;
   assign rsp_out_heading = out_h_ff;
   assign rsp_is_ego      = is_ego_ff;
   assign rsp_start_index = 12'(tracked_ff);
   assign rsp_last        = (k_ff == poses_ff);

endmodule

`default_nettype wire

// ----- rtl/lpwe_checker.sv -----
// Port-level checks for the local path window extractor, bound to the top level.
`default_nettype none

module lpwe_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [1:0]  req_operation,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_out_x,
   input wire logic        rsp_is_ego,
   input wire logic [11:0] rsp_start_index,
   input wire logic        rsp_last
);

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_last))
      else $error("stalled result word changed");

   // An accepted query blocks further input.
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_operation == lpwe_pkg::OP_QUERY |=> req_stall)
      else $error("input not held off after a query");

   // No input is taken while results are shown.
   a_out_blocks_in: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted during a result run");

   // Within a run the start index is fixed and only the first word is ego.
   a_run_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> $stable(rsp_start_index) && !rsp_is_ego)
      else $error("start index or ego flag wrong inside a run");

endmodule

bind local_path_window_extractor lpwe_checker u_lpwe_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_operation   (req_operation),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_x       (rsp_out_x),
   .rsp_is_ego      (rsp_is_ego),
   .rsp_start_index (rsp_start_index),
   .rsp_last        (rsp_last)
);

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the local path window extractor.
`default_nettype none

module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   // Codes that the package does not name.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [1:0] REG_NONE  = 2'd3;

   localparam int DEPTH      = 4096;
   localparam int TAB_BITS   = 10;
   localparam int TAB_SIZE   = 1 << TAB_BITS;
   localparam int TAB_QUART  = TAB_SIZE / 4;
   localparam int CYCLE_CAP  = 2000000;
   localparam int LONG_HOLD  = 300;

   // One emitted path point.
   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [15:0]        h;
      bit                 ego;
      logic [11:0]        idx;
      bit                 last;
   } point_type;

   // One row of the directed stimulus; the ego word is typed in where known.
   typedef struct {
      logic [1:0] op;
      int         x;
      int         y;
      int         h;
      bit         typed;
      int         ex;
      int         ey;
      int         eh;
   } row_type;

   typedef struct {
      bit on;
      int x;
      int y;
      int h;
   } known_ego_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_operation;
   logic signed [31:0] req_coord_x;
   logic signed [31:0] req_coord_y;
   logic signed [15:0] req_heading;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_out_x;
   logic signed [31:0] rsp_out_y;
   logic signed [15:0] rsp_out_heading;
   logic               rsp_is_ego;
   logic [11:0]        rsp_start_index;
   logic               rsp_last;
   logic               csr_wr_en;
   logic [1:0]         csr_index;
   logic [7:0]         csr_wr_data;

   local_path_window_extractor u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_heading     (req_heading),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_heading (rsp_out_heading),
      .rsp_is_ego      (rsp_is_ego),
      .rsp_start_index (rsp_start_index),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   // Shadow copy of the path memory, the tracker and the registers.
   logic signed [31:0] way_x [DEPTH];
   logic signed [31:0] way_y [DEPTH];
   logic [15:0]        way_h [DEPTH];
   int unsigned        path_len;
   int unsigned        track_idx;
   int unsigned        win_len;
   int unsigned        ahead_len;
   bit                 global_frame;
   longint             sine_lut [TAB_SIZE];

   point_type     pending_points [$];
   known_ego_type known_ego [$];
   int            error_count;
   int            query_count;
   int            append_count;
   int            word_count;
   int            cycle_count;
   bit            quiet;
   bit            stall_long;

   // Clock generation.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Quarter-wave sine sample in Q1.16 from a truncating Taylor series.
   function automatic longint quarter_wave(int unsigned r);
      longint unsigned arg;
      longint unsigned arg_sq;
      longint unsigned term;
      longint          acc;
      longint unsigned rounded;
      arg    = (longint'(r) * 64'd1686629713) >> (TAB_BITS - 2);
      arg_sq = (arg * arg) >> 30;
      term   = arg;
      acc    = longint'(arg);
      for (int k = 1; k <= 6; k++) begin
         term = ((term * arg_sq) >> 30) / longint'((2 * k) * (2 * k + 1));
         acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
      end
      if (acc < 0) begin
         acc = 0;
      end
      rounded = (longint'(acc) + 8192) >> 14;
      if (rounded > 65536) begin
         rounded = 65536;
      end
      return longint'(rounded);
   endfunction

   function automatic longint sine_of(logic [15:0] a);
      return sine_lut[a >> (16 - TAB_BITS)];
   endfunction

   function automatic longint cosine_of(logic [15:0] a);
      return sine_lut[((a >> (16 - TAB_BITS)) + TAB_QUART) % TAB_SIZE];
   endfunction

   // Drop 16 fraction bits, rounding half away from zero, and saturate.
   function automatic logic signed [31:0] frame_round(longint v);
      longint r;
      if (v < 0) begin
         r = -((-v + 32768) >>> 16);
      end else begin
         r = (v + 32768) >>> 16;
      end
      if (r > 64'sd2147483647) begin
         r = 64'sd2147483647;
      end
      if (r < -64'sd2147483648) begin
         r = -64'sd2147483648;
      end
      return r[31:0];
   endfunction

   // Update the path state for one accepted word and queue the points it causes.
   task automatic path_update(input logic [1:0] op, input logic signed [31:0] vx,
                              input logic signed [31:0] vy, input logic [15:0] vh);
      longint        c;
      longint        s;
      longint        dx;
      longint        dy;
      longint        ax;
      longint        ay;
      logic [65:0]   sq_dist;
      logic [65:0]   best_dist;
      int unsigned   stop;
      int unsigned   best;
      bit            found;
      point_type     run [$];
      point_type     p;
      known_ego_type ke;
      case (op)
         lpwe_pkg::OP_APPEND: begin
            if (path_len < DEPTH) begin
               way_x[path_len] = vx;
               way_y[path_len] = vy;
               way_h[path_len] = vh;
               path_len++;
            end
            append_count++;
         end
         lpwe_pkg::OP_CLEAR: begin
            path_len  = 0;
            track_idx = 0;
         end
         lpwe_pkg::OP_QUERY: begin
            c     = cosine_of(vh);
            s     = sine_of(vh);
            found = 1'b0;
            best  = 0;
            best_dist = '0;
            stop  = track_idx + win_len;
            if (stop > path_len) begin
               stop = path_len;
            end
            // Nearest waypoint ahead of the vehicle; the first one wins a tie.
            for (int unsigned i = track_idx; i < stop; i++) begin
               dx = longint'(way_x[i]) - longint'(vx);
               dy = longint'(way_y[i]) - longint'(vy);
               if (dx * c + dy * s > 0) begin
                  ax      = (dx < 0) ? -dx : dx;
                  ay      = (dy < 0) ? -dy : dy;
                  sq_dist = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
                  if (!found || sq_dist < best_dist) begin
                     found     = 1'b1;
                     best_dist = sq_dist;
                     best      = i;
                  end
               end
            end
            if (found) begin
               track_idx = best;
            end
            p.ego  = 1'b1;
            p.idx  = '0;
            p.last = 1'b0;
            p.x    = global_frame ? vx : '0;
            p.y    = global_frame ? vy : '0;
            p.h    = global_frame ? vh : '0;
            if (known_ego.size() > 0) begin
               ke = known_ego.pop_front();
               if (ke.on) begin
                  p.x = ke.x;
                  p.y = ke.y;
                  p.h = ke.h[15:0];
               end
            end
            run.insert(run.size(), p);
            p.ego = 1'b0;
            for (int unsigned i = track_idx; i < track_idx + ahead_len && i < path_len; i++) begin
               if (global_frame) begin
                  p.x = way_x[i];
                  p.y = way_y[i];
                  p.h = way_h[i];
               end else begin
                  dx  = longint'(way_x[i]) - longint'(vx);
                  dy  = longint'(way_y[i]) - longint'(vy);
                  p.x = frame_round(dx * c + dy * s);
                  p.y = frame_round(dy * c - dx * s);
                  p.h = way_h[i] - vh;
               end
               run.insert(run.size(), p);
            end
            // Short tail: repeat the previous point.
            while (run.size() < ahead_len + 1) begin
               run.insert(run.size(), p);
            end
            foreach (run[k]) begin
               run[k].idx  = track_idx[11:0];
               run[k].last = (k == run.size() - 1);
               pending_points.insert(pending_points.size(), run[k]);
            end
            query_count++;
         end
         default: begin
         end
      endcase
   endtask

   task automatic field_check(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t ns: mismatch on %s, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Result check, register shadow and prediction, all on the sampled edge.
   always @(posedge clock) begin
      point_type w;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         path_len     = 0;
         track_idx    = 0;
         win_len      = lpwe_pkg::SEARCH_WINDOW_RST;
         ahead_len    = lpwe_pkg::POSES_AHEAD_RST;
         global_frame = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            word_count++;
            if (pending_points.size() == 0) begin
               $display("%0t ns: unexpected result word x=%0d y=%0d", $time,
                        rsp_out_x, rsp_out_y);
               error_count++;
            end else begin
               w = pending_points.pop_front();
               field_check("out_x", w.x, rsp_out_x);
               field_check("out_y", w.y, rsp_out_y);
               field_check("out_heading", w.h, rsp_out_heading[15:0]);
               field_check("is_ego", w.ego, rsp_is_ego);
               field_check("start_index", w.idx, rsp_start_index);
               field_check("last", w.last, rsp_last);
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               lpwe_pkg::REG_SEARCH_WINDOW: win_len = csr_wr_data;
               lpwe_pkg::REG_POSES_AHEAD:   ahead_len = csr_wr_data[5:0];
               lpwe_pkg::REG_OUTPUT_FRAME:  global_frame = csr_wr_data[0];
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) begin
            path_update(req_operation, req_coord_x, req_coord_y, req_heading);
         end
      end
   end

   // Timeout.
   always @(posedge clock) begin
      if (cycle_count > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Receiver: short random stall bursts, and one long hold on request.
   initial begin
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (stall_long) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            stall_long = 1'b0;
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one word, with an optional idle burst first, and wait for acceptance.
   task automatic send_word(input logic [1:0] op, input int x, input int y, input int h);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_coord_x   <= x;
      req_coord_y   <= y;
      req_heading   <= h[15:0];
      do @(posedge clock); while (req_stall);
   endtask

   // Stop sending and wait until every pending point has been taken.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_points.size() != 0);
      repeat (16) @(posedge clock);
   endtask

   task automatic set_config(input int win, input int ahead, input bit frame);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_index   <= lpwe_pkg::REG_SEARCH_WINDOW;
      csr_wr_data <= win[7:0];
      @(posedge clock);
      csr_index   <= lpwe_pkg::REG_POSES_AHEAD;
      csr_wr_data <= ahead[7:0];
      @(posedge clock);
      csr_index   <= lpwe_pkg::REG_OUTPUT_FRAME;
      csr_wr_data <= {7'd0, frame};
      @(posedge clock);
      // An index past the register list must change nothing.
      csr_index   <= REG_NONE;
      csr_wr_data <= 8'($urandom);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Stimulus.
   initial begin
      row_type       plan [17];
      known_ego_type ke;
      int            phase_win [8];
      int            phase_ahead [8];
      bit            phase_frame [8];
      int            len;
      int            j;
      int            step;
      int            off;
      longint        px;
      longint        py;
      logic [15:0]   dir;
      int            xs [$];
      int            ys [$];

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_operation = lpwe_pkg::OP_APPEND;
      req_coord_x   = '0;
      req_coord_y   = '0;
      req_heading   = '0;
      csr_wr_en     = 1'b0;
      csr_index     = lpwe_pkg::REG_SEARCH_WINDOW;
      csr_wr_data   = '0;
      clock         = 1'b0;
      error_count   = 0;
      query_count   = 0;
      append_count  = 0;
      word_count    = 0;
      cycle_count   = 0;
      quiet         = 1'b0;
      stall_long    = 1'b0;

      // Full-circle sine table by quarter-wave symmetry.
      for (int n = 0; n < TAB_SIZE; n++) begin
         int q;
         int r;
         q = n / TAB_QUART;
         r = n % TAB_QUART;
         sine_lut[n] = (q % 2 == 1) ? quarter_wave(TAB_QUART - r) : quarter_wave(r);
         if (q >= 2) begin
            sine_lut[n] = -sine_lut[n];
         end
      end

      // Directed words at the reset register values: window 50, 20 points, vehicle frame.
      plan = '{
         '{lpwe_pkg::OP_QUERY,  32'h7fffffff, 32'h80000000, 32767, 1, 0, 0, 0},
         '{OP_UNUSED,           32'h12345678, 32'hedcba987, 16'h5a5a, 0, 0, 0, 0},
         '{lpwe_pkg::OP_CLEAR,  0, 0, 0, 0, 0, 0, 0},
         '{lpwe_pkg::OP_APPEND, 32'h7fffffff, 32'h80000000, 32767, 0, 0, 0, 0},
         '{lpwe_pkg::OP_APPEND, 32'h80000000, 32'h7fffffff, -32768, 0, 0, 0, 0},
         '{lpwe_pkg::OP_APPEND, 0, 0, 0, 0, 0, 0, 0},
         '{lpwe_pkg::OP_APPEND, 65536, 0, 0, 0, 0, 0, 0},
         '{lpwe_pkg::OP_APPEND, 131072, 0, 256, 0, 0, 0, 0},
         '{lpwe_pkg::OP_APPEND, 196608, 0, -1, 0, 0, 0, 0},
         '{lpwe_pkg::OP_QUERY,  0, 0, 0, 0, 0, 0, 0},
         '{lpwe_pkg::OP_QUERY,  32'h80000000, 32'h7fffffff, -32768, 1, 0, 0, 0},
         '{lpwe_pkg::OP_QUERY,  131072, -65536, 16384, 0, 0, 0, 0},
         '{lpwe_pkg::OP_CLEAR,  0, 0, 0, 0, 0, 0, 0},
         '{lpwe_pkg::OP_QUERY,  0, 0, 0, 1, 0, 0, 0},
         '{lpwe_pkg::OP_APPEND, 131072, 65536, 100, 0, 0, 0, 0},
         '{lpwe_pkg::OP_APPEND, 131072, -65536, 200, 0, 0, 0, 0},
         '{lpwe_pkg::OP_QUERY,  0, 0, 0, 0, 0, 0, 0}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[k]) begin
         if (plan[k].op == lpwe_pkg::OP_QUERY) begin
            ke.on = plan[k].typed;
            ke.x  = plan[k].ex;
            ke.y  = plan[k].ey;
            ke.h  = plan[k].eh;
            known_ego.insert(known_ego.size(), ke);
         end
         send_word(plan[k].op, plan[k].x, plan[k].y, plan[k].h);
      end

      // Register settings for the random phases, extremes included.
      phase_win   = '{1, 255, 0, 8, 20, 3, 50, 255};
      phase_ahead = '{1, 63, 0, 5, 10, 63, 20, 63};
      phase_frame = '{0, 1, 0, 1, 0, 0, 1, 1};

      for (int ph = 0; ph < 7; ph++) begin
         set_config(phase_win[ph], phase_ahead[ph], phase_frame[ph]);
         quiet = (ph == 6);
         send_word(lpwe_pkg::OP_CLEAR, int'($urandom), int'($urandom), int'($urandom));
         // A straight path in a random direction with random spacing.
         len  = $urandom_range(6, 18);
         px   = longint'($urandom_range(0, 131072000)) - 65536000;
         py   = longint'($urandom_range(0, 131072000)) - 65536000;
         dir  = 16'($urandom);
         xs.delete();
         ys.delete();
         for (int i = 0; i < len; i++) begin
            step = $urandom_range(16384, 131072);
            px   = px + ((longint'(step) * cosine_of(dir)) >>> 16);
            py   = py + ((longint'(step) * sine_of(dir)) >>> 16);
            xs.insert(xs.size(), int'(px));
            ys.insert(ys.size(), int'(py));
            send_word(lpwe_pkg::OP_APPEND, int'(px), int'(py),
                      int'(dir) + $urandom_range(0, 512) - 256);
            if ($urandom_range(0, 9) == 0) begin
               send_word(2'($urandom), int'($urandom), int'($urandom), int'($urandom));
            end
         end
         // In one phase the receiver holds off while queries keep coming.
         if (ph == 3) begin
            stall_long = 1'b1;
         end
         // Vehicle poses moving forward along the path.
         j = 0;
         for (int q = 0; q < 7 && j < len; q++) begin
            off = $urandom_range(0, 65536) - 32768;
            send_word(lpwe_pkg::OP_QUERY, xs[j] + off, ys[j] - off,
                      int'(dir) + $urandom_range(0, 2048) - 1024);
            if ($urandom_range(0, 5) == 0) begin
               send_word(2'($urandom), int'($urandom), int'($urandom), int'($urandom));
            end
            j = j + $urandom_range(0, 3);
         end
      end

      // A short path under the widest window and run, so most of the run is padding.
      set_config(phase_win[7], phase_ahead[7], phase_frame[7]);
      send_word(lpwe_pkg::OP_CLEAR, 0, 0, 0);
      for (int i = 0; i < 10; i++) begin
         send_word(lpwe_pkg::OP_APPEND, i * 4096, i * -8192, i);
      end
      send_word(lpwe_pkg::OP_QUERY, 4 * 4096, 4 * -8192, 16'hec00);

      wait_idle();
      $display("Covered %0d queries, %0d appends and %0d result words,", query_count,
               append_count, word_count);
      $display("over eight register settings, a long receiver hold and long padding runs.");
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
